// File: design/mtet_pkg.sv
// Shared widths, field positions and register indexes of the multi-turn encoder tracker.
`timescale 1ns / 1ps

package mtet_pkg;

    // The rotor angle is one full turn wide, so turns and angle concatenate
    // into the total position without a multiplier.
    localparam int ANGLE_W         = 13;
    localparam int COUNTS_PER_TURN = 2 ** ANGLE_W;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int TURN_BITS       = 24;
    localparam int DELTA_W         = ANGLE_W + 1;
    localparam int TOTAL_W         = TURN_BITS + ANGLE_W;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 8;
    localparam int WINDOW_W        = 8;

    localparam logic [COUNT_W-1:0]  COUNT_MAX      = '1;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 8'd50;

    // Slave-side payload: angle, speed, current, padded to whole bytes.
    localparam int S_ANGLE_LSB   = 0;
    localparam int S_SPEED_LSB   = S_ANGLE_LSB + ANGLE_W;
    localparam int S_CURRENT_LSB = S_SPEED_LSB + SAMPLE_W;
    localparam int S_USED_W      = S_CURRENT_LSB + SAMPLE_W;
    localparam int S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;

    // Master-side payload: angle, delta, turns, total, speed, current.
    localparam int M_ANGLE_LSB   = 0;
    localparam int M_DELTA_LSB   = M_ANGLE_LSB + ANGLE_W;
    localparam int M_TURNS_LSB   = M_DELTA_LSB + DELTA_W;
    localparam int M_TOTAL_LSB   = M_TURNS_LSB + TURN_BITS;
    localparam int M_SPEED_LSB   = M_TOTAL_LSB + TOTAL_W;
    localparam int M_CURRENT_LSB = M_SPEED_LSB + SAMPLE_W;
    localparam int M_USED_W      = M_CURRENT_LSB + SAMPLE_W;
    localparam int M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAPTURE_ENABLE = 1'b0,
        CFG_CAPTURE_WINDOW = 1'b1
    } t_cfg_index;

endpackage

// File: design/multi_turn_encoder_tracker.sv
// Top level of the multi-turn encoder tracker: offset capture, angle unwrap, position.
`timescale 1ns / 1ps

// Usage
// Each transfer on the s_axis channel carries one motor feedback frame (rotor angle,
// speed, current). Each frame yields exactly one transfer on the m_axis channel: the
// angle, the wrap-corrected step, the turn count, the total position and the speed and
// current of the last tracked frame; tuser flags a frame that only captured the offset.
// The first frames after reset (or after capture_enable is written with one) record the
// angle as the zero offset until the saturating frame counter passes capture_window.
// The frame is held in an input register, and all unwrap and position logic sits
// between that register and the result register. One frame can be taken every
// cycle while the receiver takes every result; the path that sets the clock is the
// angle subtract, wrap compare, turn increment and 37-bit position subtract.
// Reset (synchronous, active low) clears both stages, zeroes the tracking state, sets
// capture_window to 50 and arms offset capture.
// When the receiver stalls, the result holds steady; the input register still takes
// one more frame, and s_axis_tready drops only once both stages are full.
// The configuration port is a plain write port; write it only while no frame is in
// flight.
module multi_turn_encoder_tracker
    import mtet_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [WINDOW_W-1:0]    i_cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: angle_raw, speed_raw, current_raw, zero padding.
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: angle_now, step_delta, turns, total_position, speed_out,
    // current_out.
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: capturing.
    output logic                   m_axis_tuser
);

    localparam logic signed [DELTA_W-1:0] HALF_POS = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] HALF_NEG = -DELTA_W'(HALF_TURN);
    localparam logic [DELTA_W-1:0]        TURN_D   = DELTA_W'(COUNTS_PER_TURN);

    // Input stage.
    logic                 r_in_valid;
    logic [ANGLE_W-1:0]   r_angle;
    logic [SAMPLE_W-1:0]  r_speed;
    logic [SAMPLE_W-1:0]  r_current;

    // Tracking state. The held delta, speed, current and turn count double as the
    // result register fields, since they change only when a new result is loaded.
    logic [WINDOW_W-1:0]  r_capture_window;
    logic [COUNT_W-1:0]   r_frame_count;
    logic                 r_capture_active;
    logic [ANGLE_W-1:0]   r_angle_prev;
    logic [ANGLE_W-1:0]   r_zero_offset;
    logic [TURN_BITS-1:0] r_turn_counter;
    logic [DELTA_W-1:0]   r_delta_held;
    logic [SAMPLE_W-1:0]  r_speed_held;
    logic [SAMPLE_W-1:0]  r_current_held;

    // Result stage.
    logic                 r_out_valid;
    logic                 r_capturing;
    logic [ANGLE_W-1:0]   r_angle_now;
    logic [TOTAL_W-1:0]   r_total;

    logic                 advance;
    logic                 capture_now;
    logic signed [DELTA_W-1:0] diff;
    logic [COUNT_W-1:0]   n_frame_count;
    logic [ANGLE_W-1:0]   n_zero_offset;
    logic [TURN_BITS-1:0] n_turn_counter;
    logic [DELTA_W-1:0]   n_delta_held;
    logic [SAMPLE_W-1:0]  n_speed_held;
    logic [SAMPLE_W-1:0]  n_current_held;
    logic [TOTAL_W-1:0]   n_total;

    // A frame moves from the input register to the result register when the
    // result register is empty or its contents are taken in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_frame_count = (r_frame_count == COUNT_MAX) ? r_frame_count
                                                     : r_frame_count + COUNT_W'(1);
        // Capture ends once the updated count exceeds the window.
        capture_now = r_capture_active && (n_frame_count <= r_capture_window);

        diff = DELTA_W'({1'b0, r_angle}) - DELTA_W'({1'b0, r_angle_prev});

        n_zero_offset  = r_zero_offset;
        n_turn_counter = r_turn_counter;
        n_delta_held   = r_delta_held;
        n_speed_held   = r_speed_held;
        n_current_held = r_current_held;

        if (capture_now) begin
            n_zero_offset = r_angle;
        end else begin
            n_speed_held   = r_speed;
            n_current_held = r_current;
            if (diff > HALF_POS) begin
                // Forward jump of more than half a turn: wrapped backward.
                n_turn_counter = r_turn_counter - TURN_BITS'(1);
                n_delta_held   = diff - TURN_D;
            end else if (diff < HALF_NEG) begin
                n_turn_counter = r_turn_counter + TURN_BITS'(1);
                n_delta_held   = diff + TURN_D;
            end else begin
                n_delta_held   = diff;
            end
        end

        // turns * COUNTS_PER_TURN + angle is the concatenation of the two.
        n_total = {n_turn_counter, r_angle} - TOTAL_W'(n_zero_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_angle   <= s_axis_tdata[S_ANGLE_LSB +: ANGLE_W];
            r_speed   <= s_axis_tdata[S_SPEED_LSB +: SAMPLE_W];
            r_current <= s_axis_tdata[S_CURRENT_LSB +: SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_window <= WINDOW_RESET;
            r_capture_active <= 1'b1;
            r_frame_count    <= '0;
            r_angle_prev     <= '0;
            r_zero_offset    <= '0;
            r_turn_counter   <= '0;
            r_delta_held     <= '0;
            r_speed_held     <= '0;
            r_current_held   <= '0;
        end else begin
            if (i_cfg_we && (t_cfg_index'(i_cfg_addr) == CFG_CAPTURE_WINDOW)) begin
                r_capture_window <= i_cfg_wdata;
            end
            // Writing capture_enable re-arms or cancels capture directly.
            if (i_cfg_we && (t_cfg_index'(i_cfg_addr) == CFG_CAPTURE_ENABLE)) begin
                r_capture_active <= i_cfg_wdata[0];
            end else if (advance) begin
                r_capture_active <= capture_now;
            end
            if (advance) begin
                r_frame_count  <= n_frame_count;
                r_angle_prev   <= r_angle;
                r_zero_offset  <= n_zero_offset;
                r_turn_counter <= n_turn_counter;
                r_delta_held   <= n_delta_held;
                r_speed_held   <= n_speed_held;
                r_current_held <= n_current_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_capturing <= capture_now;
            r_angle_now <= r_angle;
            r_total     <= n_total;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_capturing;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[M_ANGLE_LSB   +: ANGLE_W]   = r_angle_now;
        m_axis_tdata[M_DELTA_LSB   +: DELTA_W]   = r_delta_held;
        m_axis_tdata[M_TURNS_LSB   +: TURN_BITS] = r_turn_counter;
        m_axis_tdata[M_TOTAL_LSB   +: TOTAL_W]   = r_total;
        m_axis_tdata[M_SPEED_LSB   +: SAMPLE_W]  = r_speed_held;
        m_axis_tdata[M_CURRENT_LSB +: SAMPLE_W]  = r_current_held;
    end

endmodule

// File: design/mtet_checker.sv
// Port-level assertions for the multi-turn encoder tracker and their bind.
`timescale 1ns / 1ps

module mtet_checker
    import mtet_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [WINDOW_W-1:0]   i_cfg_wdata,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tuser
);

    localparam logic signed [DELTA_W-1:0] STEP_MAX = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] STEP_MIN = -DELTA_W'(HALF_TURN);

    logic signed [DELTA_W-1:0] step;
    logic [TURN_BITS-1:0]      turns;
    logic [TOTAL_W-1:0]        total;

    assign step  = m_axis_tdata[M_DELTA_LSB +: DELTA_W];
    assign turns = m_axis_tdata[M_TURNS_LSB +: TURN_BITS];
    assign total = m_axis_tdata[M_TOTAL_LSB +: TOTAL_W];

    // A capture frame sits exactly on the offset, so the position is whole turns.
    a_capture_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (total == {turns, {ANGLE_W{1'b0}}}))
        else $error("capture result position is not a whole number of turns");

    // The unwrapped step never exceeds half a turn.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (step <= STEP_MAX) && (step >= STEP_MIN))
        else $error("step delta outside half a turn");

    // A stalled result stays offered and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed or was dropped");

    // Reset empties the block.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind multi_turn_encoder_tracker mtet_checker u_mtet_checker (.*);

// File: tb/encoder_track_checker.sv
// Checker for the multi-turn encoder tracker: predicts each frame result and compares it.
`timescale 1ns / 1ps

module encoder_track_checker
    import mtet_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [WINDOW_W-1:0]    i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                   m_axis_tuser,
    output int                     o_fail_count,
    output int                     o_results_seen
);

    typedef struct {
        logic                   capturing;
        logic [ANGLE_W-1:0]     angle;
        logic [DELTA_W-1:0]     delta;
        logic [TURN_BITS-1:0]   turns;
        logic [TOTAL_W-1:0]     total;
        logic [SAMPLE_W-1:0]    speed;
        logic [SAMPLE_W-1:0]    current;
    } t_frame_result;

    t_frame_result expected_frames[$];

    logic [WINDOW_W-1:0]    cap_window;
    logic [COUNT_W-1:0]     frame_cnt;
    logic                   cap_active;
    logic [ANGLE_W-1:0]     prev_angle;
    logic [ANGLE_W-1:0]     zero_offset;
    logic [TURN_BITS-1:0]   turn_cnt;
    logic [DELTA_W-1:0]     held_delta;
    logic [SAMPLE_W-1:0]    held_speed;
    logic [SAMPLE_W-1:0]    held_current;

    int mismatch_cnt = 0;
    int result_cnt   = 0;

    function automatic t_frame_result unwrap_frame(input logic [ANGLE_W-1:0] angle,
                                                   input logic [SAMPLE_W-1:0] speed,
                                                   input logic [SAMPLE_W-1:0] current);
        int            diff;
        int            step_val;
        t_frame_result r;
        if (frame_cnt != COUNT_MAX) begin
            frame_cnt = frame_cnt + 1'b1;
        end
        if (frame_cnt > cap_window) begin
            cap_active = 1'b0;
        end
        if (cap_active) begin
            prev_angle  = angle;
            zero_offset = angle;
            r.capturing = 1'b1;
        end else begin
            diff       = int'(angle) - int'(prev_angle);
            prev_angle = angle;
            if (diff > HALF_TURN) begin
                turn_cnt = turn_cnt - 1'b1;
                step_val = diff - COUNTS_PER_TURN;
            end else if (diff < -HALF_TURN) begin
                turn_cnt = turn_cnt + 1'b1;
                step_val = diff + COUNTS_PER_TURN;
            end else begin
                step_val = diff;
            end
            held_delta   = step_val[DELTA_W-1:0];
            held_speed   = speed;
            held_current = current;
            r.capturing  = 1'b0;
        end
        r.angle   = angle;
        r.delta   = held_delta;
        r.turns   = turn_cnt;
        r.total   = {turn_cnt, {ANGLE_W{1'b0}}} + TOTAL_W'(angle) - TOTAL_W'(zero_offset);
        r.speed   = held_speed;
        r.current = held_current;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: result %0d field %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, result_cnt, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            cap_window   = WINDOW_RESET;
            frame_cnt    = '0;
            cap_active   = 1'b1;
            prev_angle   = '0;
            zero_offset  = '0;
            turn_cnt     = '0;
            held_delta   = '0;
            held_speed   = '0;
            held_current = '0;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CAPTURE_ENABLE: begin
                        cap_active = i_cfg_wdata[0];
                    end
                    CFG_CAPTURE_WINDOW: begin
                        cap_window = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_frames.push_back(unwrap_frame(
                    s_axis_tdata[S_ANGLE_LSB +: ANGLE_W],
                    s_axis_tdata[S_SPEED_LSB +: SAMPLE_W],
                    s_axis_tdata[S_CURRENT_LSB +: SAMPLE_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_frames.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_frames.pop_front();
                    compare_field("capturing", want.capturing, m_axis_tuser);
                    compare_field("angle_now", want.angle,
                                  m_axis_tdata[M_ANGLE_LSB +: ANGLE_W]);
                    compare_field("step_delta", want.delta,
                                  m_axis_tdata[M_DELTA_LSB +: DELTA_W]);
                    compare_field("turns", want.turns,
                                  m_axis_tdata[M_TURNS_LSB +: TURN_BITS]);
                    compare_field("total_position", want.total,
                                  m_axis_tdata[M_TOTAL_LSB +: TOTAL_W]);
                    compare_field("speed_out", want.speed,
                                  m_axis_tdata[M_SPEED_LSB +: SAMPLE_W]);
                    compare_field("current_out", want.current,
                                  m_axis_tdata[M_CURRENT_LSB +: SAMPLE_W]);
                end
                result_cnt++;
            end
        end
        o_fail_count   <= mismatch_cnt;
        o_results_seen <= result_cnt;
    end

endmodule

// File: tb/tb_multi_turn_encoder_tracker.sv
// Testbench top for the multi-turn encoder tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_multi_turn_encoder_tracker;
    import mtet_pkg::*;

    // A correct run never goes this long without a transfer or a register write.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int FRAMES_PER_PHASE = 367;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = CFG_CAPTURE_ENABLE;
    logic [WINDOW_W-1:0]    i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: angle_raw, speed_raw, current_raw, zero padding.
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: angle_now, step_delta, turns, total_position, speed_out,
    // current_out.
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // Fields from bit 0: capturing.
    logic                   m_axis_tuser;

    int fail_count;
    int results_seen;

    // Pacing of both sides, in percent of cycles spent idle.
    int tx_idle_pct = 34;
    int rx_idle_pct = 65;

    int frames_sent = 0;
    int reg_writes  = 0;
    logic [ANGLE_W-1:0] last_angle = '0;

    multi_turn_encoder_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    encoder_track_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // The receiver decides afresh at every edge whether it takes a result.
    initial begin
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // The watchdog ends the run once nothing has moved for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout at %0t after %0d quiet cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
    end

    // Offers one feedback frame, after an optional idle gap, and returns at the edge
    // where the transfer takes place. Each cycle of the gap is decided on its own, so
    // the sender idles in the set share of cycles. The valid is left high so that
    // back-to-back frames stay back to back.
    task automatic send_frame(input logic [ANGLE_W-1:0] angle,
                              input logic [SAMPLE_W-1:0] speed,
                              input logic [SAMPLE_W-1:0] current);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - S_USED_W){1'b0}}, current, speed, angle};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        frames_sent++;
        last_angle = angle;
    endtask

    // Register writes only happen with the pipeline empty: every frame sent has had
    // its result taken. The write enable is lowered again before returning.
    task automatic write_reg(input t_cfg_index idx, input logic [WINDOW_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != frames_sent) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    initial begin
        int phase;
        int remaining;
        int blk;
        int kind;
        int dir;
        int stride;
        logic [ANGLE_W-1:0]  angle;
        logic [SAMPLE_W-1:0] speed;
        logic [SAMPLE_W-1:0] current;
        logic [WINDOW_W-1:0] window;

        dir = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset capture is armed with a window of 50, so these frames only
        // set the zero offset; the last one leaves it at half a turn.
        send_frame(13'd0, 16'h8000, 16'h7fff);
        send_frame(13'd8191, 16'h7fff, 16'h8000);
        send_frame(13'd4096, 16'h0000, 16'hffff);

        // A window of zero ends capture on the next frame. The angles walk through
        // both sides of the half-turn limit, forward and backward wraps, a zero step
        // and a wrap by a single count.
        write_reg(CFG_CAPTURE_WINDOW, 8'd0);
        send_frame(13'd8191, 16'h7fff, 16'h8000);
        send_frame(13'd0, 16'h8000, 16'h7fff);
        send_frame(13'd4096, 16'hffff, 16'h0000);
        send_frame(13'd0, 16'h0001, 16'hfffe);
        send_frame(13'd4097, 16'h5555, 16'haaaa);
        send_frame(13'd0, 16'haaaa, 16'h5555);
        send_frame(13'd0, 16'h1234, 16'hedcb);
        send_frame(13'd8191, 16'h8000, 16'h8000);
        send_frame(13'd8191, 16'h7fff, 16'h7fff);

        // Arming capture with the frame counter already past the window is
        // cancelled again by the very next frame.
        write_reg(CFG_CAPTURE_ENABLE, 8'd1);
        send_frame(13'd100, 16'h0f0f, 16'hf0f0);

        // The top window never ends capture, so the offset moves while speed and
        // current stay at the last tracked values.
        write_reg(CFG_CAPTURE_WINDOW, 8'd255);
        write_reg(CFG_CAPTURE_ENABLE, 8'd1);
        send_frame(13'd2000, 16'h4000, 16'hc000);
        send_frame(13'd7000, 16'hc000, 16'h4000);

        // Clearing the enable stops capture at once.
        write_reg(CFG_CAPTURE_ENABLE, 8'd0);
        send_frame(13'd6000, 16'h0100, 16'hff00);
        send_frame(13'd1500, 16'hff00, 16'h0100);

        // The highest window in the normal range still captures while the count is
        // below it.
        write_reg(CFG_CAPTURE_WINDOW, 8'd254);
        write_reg(CFG_CAPTURE_ENABLE, 8'd1);
        send_frame(13'd3333, 16'h0000, 16'h0000);

        // Random part in three pacing phases. Each block of frames runs under a
        // fresh register setting. Most angles follow a rotation in one direction,
        // so the turn count drifts and wraps happen often; the rest sit right at the
        // half-turn limit or jump anywhere.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 34;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            remaining = FRAMES_PER_PHASE;
            while (remaining > 0) begin
                if ($urandom_range(7) == 0) begin
                    // Once the frame counter has saturated, only the top window
                    // lets capture run.
                    write_reg(CFG_CAPTURE_WINDOW, 8'd255);
                    write_reg(CFG_CAPTURE_ENABLE, 8'd1);
                end else begin
                    case ($urandom_range(3))
                        0:       window = 8'd0;
                        1:       window = 8'd254;
                        default: window = 8'($urandom_range(255));
                    endcase
                    write_reg(CFG_CAPTURE_WINDOW, window);
                    write_reg(CFG_CAPTURE_ENABLE, 8'($urandom_range(1)));
                end
                blk = $urandom_range(80, 20);
                if (blk > remaining) begin
                    blk = remaining;
                end
                repeat (blk) begin
                    kind = $urandom_range(9);
                    if (kind < 6) begin
                        if ($urandom_range(15) == 0) begin
                            dir = -dir;
                        end
                        stride = dir * int'($urandom_range(1500));
                        angle  = ANGLE_W'(int'(last_angle) + stride);
                    end else if (kind == 6) begin
                        stride = ($urandom_range(1) != 0) ? 1 : -1;
                        stride = stride * (HALF_TURN - 1 + int'($urandom_range(2)));
                        angle  = ANGLE_W'(int'(last_angle) + stride);
                    end else begin
                        angle = ANGLE_W'($urandom);
                    end
                    if ($urandom_range(15) == 0) begin
                        speed = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
                    end else begin
                        speed = SAMPLE_W'($urandom);
                    end
                    if ($urandom_range(15) == 0) begin
                        current = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
                    end else begin
                        current = SAMPLE_W'($urandom);
                    end
                    send_frame(angle, speed, current);
                end
                remaining -= blk;
            end
        end

        // Drain: every result must arrive, then a further wait catches any extra
        // transfer the block might still produce.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != frames_sent) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);

        $display("Run covered %0d feedback frames, %0d checked results, %0d register writes",
                 frames_sent, results_seen, reg_writes);
        $display("Windows 0, 50, 254 and 255, capture armed and cancelled, three pacings");
        if (fail_count == 0 && results_seen == frames_sent) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
